### rtl/core/fsrs_pkg.sv
// fsrs_pkg: shared types, widths and codes for the frame slot ring store
// no dependencies; imported by every module of the block
`default_nettype none

package fsrs_pkg;

    localparam int HANDLE_BITS    = 32;
    localparam int IDX_W          = 32;
    localparam int CNT_W          = 7;
    localparam int MODE_W         = 2;
    localparam int OP_W           = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 7;
    localparam int MAX_FRAMES_DEF = 64;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PASS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CIRC  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RO       = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [HANDLE_BITS-1:0]   frame_handle;
        logic signed [IDX_W-1:0]  read_index;
        logic                     loader_busy;
    } in_item_t;

    typedef struct packed {
        logic                     accepted;
        logic [HANDLE_BITS-1:0]   frame_out;
        logic                     is_empty;
        logic [CNT_W-1:0]         frame_count;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic neg_msb;
    } mod_ctl_t;

endpackage

`default_nettype wire

### rtl/core/fsrs_serial_mod.sv
// fsrs_serial_mod: bit-serial remainder of a 32-bit word by a 7-bit divisor
// one dividend bit per cycle, msb first; uses fsrs_pkg
`default_nettype none

module fsrs_serial_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fsrs_pkg::mod_ctl_t          ctl,
    input  logic [fsrs_pkg::IDX_W-1:0]  value,
    input  logic [fsrs_pkg::CNT_W-1:0]  divisor,
    output logic                        done,
    output logic [fsrs_pkg::CNT_W-1:0]  rem
);
    import fsrs_pkg::*;

    localparam int STEP_W = $clog2(IDX_W);

    logic [IDX_W-2:0]  sh_reg;
    logic [CNT_W-1:0]  r_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CNT_W-1:0]  r_init;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic [CNT_W-1:0]  r_next;

    // with ctl.neg_msb set the sign bit carries weight -2^31, else +2^31
    always_comb
    begin
        if (!value[IDX_W-1])
            r_init = '0;
        else if (ctl.neg_msb)
            r_init = divisor - CNT_W'(1);
        else if (divisor == CNT_W'(1))
            r_init = '0;
        else
            r_init = CNT_W'(1);
    end

    always_comb
    begin
        trial     = {r_reg, sh_reg[IDX_W-2]};
        trial_sub = trial - {1'b0, div_reg};
        r_next    = (trial >= {1'b0, div_reg}) ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg   <= '0;
            r_reg    <= '0;
            div_reg  <= CNT_W'(1);
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                sh_reg   <= value[IDX_W-2:0];
                r_reg    <= r_init;
                div_reg  <= divisor;
                cnt_reg  <= STEP_W'(IDX_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                sh_reg  <= sh_reg << 1;
                r_reg   <= r_next;
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

`default_nettype wire

### rtl/core/fsrs_slot_mem.sv
// fsrs_slot_mem: single-port-write, single-port-read slot memory
// read data registered; uses fsrs_pkg for the handle width
`default_nettype none

module fsrs_slot_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic [fsrs_pkg::HANDLE_BITS-1:0]  wr_data,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic [fsrs_pkg::HANDLE_BITS-1:0]  rd_data
);
    import fsrs_pkg::*;

    logic [HANDLE_BITS-1:0] frame_store [DEPTH];
    logic [HANDLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_store[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= frame_store[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/frame_slot_ring_store.sv
// frame_slot_ring_store: top level, control sequencer and result register
// uses fsrs_pkg, fsrs_serial_mod and fsrs_slot_mem
//
// One transaction is worked at a time. A push, clear or unknown op goes from S_EXEC to
// S_FINISH; a read of a non-empty store in fixed or circular mode forms the bit-serial
// remainder of the 32-bit index by the frame count (one bit per cycle) in S_MOD, then
// does one registered memory read in S_MEM; a passthrough read goes straight to S_MEM.
// S_FINISH registers the result once the output is free. The next transaction can be
// accepted in the cycle after the result is registered. A capacity write starts a pass
// that reduces the head pointer modulo the new capacity; cfg_ready is low and item_stall
// high during it. A finished result sits in the output register as the next is accepted.
`default_nettype none

module frame_slot_ring_store #(
    parameter int MAX_FRAMES = fsrs_pkg::MAX_FRAMES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  fsrs_pkg::in_item_t               item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output fsrs_pkg::out_item_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fsrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fsrs_pkg::*;

    localparam int SLOT_DEPTH = (MAX_FRAMES > 127) ? 127 : MAX_FRAMES;
    localparam int SLOT_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam logic [CNT_W:0] MAX_CAP = (CNT_W + 1)'(SLOT_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOD,
        S_MEM,
        S_FINISH,
        S_NORM,
        S_NORM_WAIT
    } state_t;

    state_t                 state_reg;
    logic [MODE_W-1:0]      mode_reg;
    logic [CNT_W-1:0]       cap_reg;
    logic                   ro_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SLOT_W-1:0]      oldest_reg;
    logic [OP_W-1:0]        op_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [IDX_W-1:0]       index_reg;
    logic                   lbusy_reg;
    logic                   res_acc_reg;
    logic [HANDLE_BITS-1:0] res_frame_reg;
    out_item_t              result_reg;
    logic                   result_valid_reg;

    logic [CNT_W-1:0]       cap_eff;
    logic                   full;
    logic [CNT_W:0]         sum_push;
    logic [CNT_W:0]         sum_push_sub;
    logic [CNT_W:0]         sum_rd;
    logic [CNT_W:0]         sum_rd_sub;
    logic [CNT_W:0]         oldest_plus;
    logic [SLOT_W-1:0]      push_slot;
    logic [SLOT_W-1:0]      rd_slot;
    logic [SLOT_W-1:0]      oldest_inc;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic [HANDLE_BITS-1:0] rd_data;
    mod_ctl_t               mod_ctl;
    logic [IDX_W-1:0]       mod_value;
    logic [CNT_W-1:0]       mod_divisor;
    logic                   mod_done;
    logic [CNT_W-1:0]       mod_rem;
    logic                   out_free;
    logic                   is_read_serial;

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CNT_W'(1);
        else if ({1'b0, cap_reg} > MAX_CAP)
            cap_eff = MAX_CAP[CNT_W-1:0];
        else
            cap_eff = cap_reg;

        full = (count_reg >= cap_eff);

        sum_push     = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(count_reg);
        sum_push_sub = sum_push - {1'b0, cap_eff};
        push_slot    = (sum_push >= {1'b0, cap_eff}) ? sum_push_sub[SLOT_W-1:0]
                                                     : sum_push[SLOT_W-1:0];

        sum_rd     = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(mod_rem);
        sum_rd_sub = sum_rd - {1'b0, cap_eff};
        rd_slot    = (sum_rd >= {1'b0, cap_eff}) ? sum_rd_sub[SLOT_W-1:0]
                                                 : sum_rd[SLOT_W-1:0];

        oldest_plus = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(1);
        oldest_inc  = (oldest_plus >= {1'b0, cap_eff}) ? '0 : oldest_plus[SLOT_W-1:0];
    end

    always_comb
    begin
        wr_en = (state_reg == S_EXEC) && (op_reg == OP_PUSH) && !ro_reg && !lbusy_reg &&
                ((mode_reg == MODE_PASS) ||
                 ((mode_reg == MODE_FIXED) && !full) ||
                 (mode_reg == MODE_CIRC));
        if (mode_reg == MODE_PASS)
            wr_addr = '0;
        else if (!full)
            wr_addr = push_slot;
        else
            wr_addr = oldest_reg;

        is_read_serial = (state_reg == S_EXEC) && (op_reg == OP_READ) &&
                         (count_reg != '0) && (mode_reg != MODE_PASS);

        rd_en = ((state_reg == S_EXEC) && (op_reg == OP_READ) && (count_reg != '0) &&
                 (mode_reg == MODE_PASS)) ||
                ((state_reg == S_MOD) && mod_done);
        rd_addr = (state_reg == S_MOD) ? rd_slot : '0;

        mod_ctl.start   = is_read_serial || (state_reg == S_NORM);
        mod_ctl.neg_msb = (state_reg == S_EXEC);
        mod_value       = (state_reg == S_NORM) ? IDX_W'(oldest_reg) : index_reg;
        mod_divisor     = (state_reg == S_NORM) ? cap_eff : count_reg;
    end

    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready  = (state_reg == S_IDLE);

    fsrs_serial_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mod_ctl),
        .value   (mod_value),
        .divisor (mod_divisor),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    fsrs_slot_mem #(
        .DEPTH  (SLOT_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (handle_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= MODE_FIXED;
            cap_reg          <= CNT_W'(1);
            ro_reg           <= 1'b0;
            count_reg        <= '0;
            oldest_reg       <= '0;
            op_reg           <= OP_PUSH;
            handle_reg       <= '0;
            index_reg        <= '0;
            lbusy_reg        <= 1'b0;
            res_acc_reg      <= 1'b0;
            res_frame_reg    <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            CFG_MODE:     mode_reg <= cfg_data[MODE_W-1:0];
                            CFG_CAPACITY:
                            begin
                                cap_reg   <= cfg_data;
                                state_reg <= S_NORM;
                            end
                            CFG_RO:       ro_reg <= cfg_data[0];
                            default:      ;
                        endcase
                    end
                    else if (item_valid)
                    begin
                        op_reg     <= item.op;
                        handle_reg <= item.frame_handle;
                        index_reg  <= item.read_index;
                        lbusy_reg  <= item.loader_busy;
                        state_reg  <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    res_frame_reg <= '0;
                    case (op_reg)
                        OP_PUSH:
                        begin
                            res_acc_reg <= wr_en;
                            if (wr_en)
                            begin
                                if (mode_reg == MODE_PASS)
                                begin
                                    if (count_reg == '0)
                                        count_reg <= CNT_W'(1);
                                end
                                else if (!full)
                                    count_reg <= count_reg + CNT_W'(1);
                                else
                                    oldest_reg <= oldest_inc;
                            end
                            state_reg <= S_FINISH;
                        end
                        OP_READ:
                        begin
                            res_acc_reg <= 1'b1;
                            if (count_reg == '0)
                                state_reg <= S_FINISH;
                            else if (mode_reg == MODE_PASS)
                                state_reg <= S_MEM;
                            else
                                state_reg <= S_MOD;
                        end
                        OP_CLEAR:
                        begin
                            res_acc_reg <= 1'b1;
                            count_reg   <= '0;
                            oldest_reg  <= '0;
                            state_reg   <= S_FINISH;
                        end
                        default:
                        begin
                            res_acc_reg <= 1'b0;
                            state_reg   <= S_FINISH;
                        end
                    endcase
                end

                S_MOD:
                begin
                    if (mod_done)
                        state_reg <= S_MEM;
                end

                S_MEM:
                begin
                    res_frame_reg <= rd_data;
                    state_reg     <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        result_reg.accepted    <= res_acc_reg;
                        result_reg.frame_out   <= res_frame_reg;
                        result_reg.is_empty    <= (count_reg == '0);
                        result_reg.frame_count <= count_reg;
                        result_valid_reg       <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end

                S_NORM:
                begin
                    if (count_reg > cap_eff)
                        count_reg <= cap_eff;
                    state_reg <= S_NORM_WAIT;
                end

                S_NORM_WAIT:
                begin
                    if (mod_done)
                    begin
                        oldest_reg <= mod_rem[SLOT_W-1:0];
                        state_reg  <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire
